[rtl/core/wpc_pkg.sv]
// Shared constants, codes and types of the widest path capacity block.
`timescale 1ns / 1ps

package wpc_pkg;

    localparam int MAX_NODES  = 64;
    localparam int MAX_EDGES  = 1024;

    localparam int NODE_W     = 7;
    localparam int NODE_IDX_W = $clog2(MAX_NODES);
    localparam int EDGE_ADDR_W = $clog2(MAX_EDGES);
    localparam int FILL_W     = EDGE_ADDR_W + 1;
    localparam int CAP_W      = 16;
    localparam int BOTT_W     = 17;
    localparam int OP_W       = 2;
    localparam int STAT_W     = 2;

    localparam logic [BOTT_W-1:0] CAP_UNBOUNDED = BOTT_W'(65536);

    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE   = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNREACH = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [NODE_IDX_W-1:0] tail;
        logic [NODE_IDX_W-1:0] head;
        logic [CAP_W-1:0]      cap;
    } wpc_edge_t;

    typedef struct packed {
        logic [NODE_IDX_W-1:0] src;
        logic [NODE_IDX_W-1:0] dst;
        logic [NODE_W-1:0]     nodes;
    } wpc_req_t;

    typedef struct packed {
        logic [BOTT_W-1:0] bottleneck;
        logic [STAT_W-1:0] status;
    } wpc_res_t;

endpackage

[rtl/core/widest_path_capacity.sv]
// Top level of the widest path capacity block: request decode, edge store, result register.
`timescale 1ns / 1ps
// Add, clear and other non-query requests: result strobed in the cycle after acceptance,
// and a new request may be taken every cycle. A query holds busy for one node scan per
// reached node plus one that finds none (node_count capped at 64 nodes per scan), reads
// every stored edge per reached node and relaxes each one leaving it, then fetches and strobes
// the answer; the one best-capacity RAM port and the shared comparator serialise these steps.
// Reset (rst_n low, asynchronous) empties the edge store, zeroes node_count and drops busy.

module widest_path_capacity
    import wpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   operation,
    input  logic [NODE_W-1:0] from_node,
    input  logic [NODE_W-1:0] to_node,
    input  logic [CAP_W-1:0]  edge_capacity,
    output logic              done,
    output logic [BOTT_W-1:0] bottleneck,
    output logic [STAT_W-1:0] status,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [NODE_W-1:0] cfg_data
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [BOTT_W-1:0] bott_reg, bott_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [NODE_W-1:0] node_count_reg;

    logic              accept;
    logic [NODE_W-1:0] nodes_act;
    logic              add_ok, query_ok;
    logic              go;
    wpc_req_t          req;

    logic                   edge_we;
    wpc_edge_t              edge_wdata;
    logic                   edge_re;
    logic [EDGE_ADDR_W-1:0] edge_raddr;
    wpc_edge_t              edge_rdata;
    logic                   fin;
    wpc_res_t               res;

    assign accept = start && !busy_reg;

    // Saturate the node count at the graph capacity.
    assign nodes_act = (node_count_reg > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES)
                                                             : node_count_reg;

    // Edges are checked against the store's node range, queries against the loaded graph.
    assign add_ok = (from_node != '0) && (from_node <= NODE_W'(MAX_NODES))
                    && (to_node != '0) && (to_node <= NODE_W'(MAX_NODES));
    assign query_ok = (from_node != '0) && (from_node <= nodes_act)
                      && (to_node != '0) && (to_node <= nodes_act);

    assign go        = accept && (operation == OP_QUERY) && query_ok;
    assign req.src   = NODE_IDX_W'(from_node - NODE_W'(1));
    assign req.dst   = NODE_IDX_W'(to_node - NODE_W'(1));
    assign req.nodes = nodes_act;

    // Write the edge at the fill point in the cycle the request is taken.
    assign edge_we = accept && (operation == OP_ADD) && add_ok
                     && (fill_reg < FILL_W'(MAX_EDGES));
    assign edge_wdata.tail = NODE_IDX_W'(from_node - NODE_W'(1));
    assign edge_wdata.head = NODE_IDX_W'(to_node - NODE_W'(1));
    assign edge_wdata.cap  = edge_capacity;

    wpc_ram #(
        .WIDTH($bits(wpc_edge_t)),
        .DEPTH(MAX_EDGES)
    ) u_edge_ram (
        .clk  (clk),
        .we   (edge_we),
        .waddr(fill_reg[EDGE_ADDR_W-1:0]),
        .wdata(edge_wdata),
        .re   (edge_re),
        .raddr(edge_raddr),
        .rdata(edge_rdata)
    );

    wpc_search u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .req       (req),
        .fill      (fill_reg),
        .edge_re   (edge_re),
        .edge_raddr(edge_raddr),
        .edge_rdata(edge_rdata),
        .fin       (fin),
        .res       (res)
    );

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        bott_next   = bott_reg;
        status_next = status_reg;
        fill_next   = fill_reg;

        if (accept)
        begin
            // every request except a launched search answers on the next cycle
            done_next   = 1'b1;
            bott_next   = '0;
            status_next = ST_OK;
            case (operation)
                OP_ADD:
                begin
                    if (!add_ok)
                    begin
                        status_next = ST_RANGE;
                    end
                    else if (fill_reg >= FILL_W'(MAX_EDGES))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
                OP_QUERY:
                begin
                    if (query_ok)
                    begin
                        done_next = 1'b0;
                        busy_next = 1'b1;
                    end
                    else
                    begin
                        status_next = ST_RANGE;
                    end
                end
                OP_CLEAR:
                begin
                    fill_next = '0;
                end
                default:
                begin
                    fill_next = fill_reg;
                end
            endcase
        end

        // drop busy as the search result is captured
        if (fin)
        begin
            done_next   = 1'b1;
            bott_next   = res.bottleneck;
            status_next = res.status;
            busy_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            done_reg       <= 1'b0;
            fill_reg       <= '0;
            node_count_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            fill_reg <= fill_next;
            if (cfg_valid && cfg_ready)
            begin
                node_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bott_reg   <= bott_next;
        status_reg <= status_next;
    end

    assign busy       = busy_reg;
    assign cfg_ready  = !busy_reg;
    assign done       = done_reg;
    assign bottleneck = bott_reg;
    assign status     = status_reg;

endmodule

[rtl/core/wpc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module wpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/wpc_search.sv]
// Widest-path search sequencer: node scan, edge relaxation, one shared comparator.
`timescale 1ns / 1ps

module wpc_search
    import wpc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   go,
    input  wpc_req_t               req,
    input  logic [FILL_W-1:0]      fill,
    output logic                   edge_re,
    output logic [EDGE_ADDR_W-1:0] edge_raddr,
    input  wpc_edge_t              edge_rdata,
    output logic                   fin,
    output wpc_res_t               res
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_RADDR = 3'd2;
    localparam logic [2:0] S_REDGE = 3'd3;
    localparam logic [2:0] S_RBEST = 3'd4;
    localparam logic [2:0] S_FRD   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [MAX_NODES-1:0]  node_done_reg, node_done_next;
    logic [MAX_NODES-1:0]  best_vld_reg, best_vld_next;
    logic [NODE_W-1:0]     nodes_reg, nodes_next;
    logic [NODE_IDX_W-1:0] dst_reg, dst_next;
    logic [NODE_W-1:0]     scan_cnt_reg, scan_cnt_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [NODE_IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic                  pick_found_reg, pick_found_next;
    logic [NODE_IDX_W-1:0] pick_reg, pick_next;
    logic [BOTT_W-1:0]     pick_val_reg, pick_val_next;
    logic [FILL_W-1:0]     k_reg, k_next;
    logic [BOTT_W-1:0]     cand_reg, cand_next;

    // shared compare unit
    logic [BOTT_W-1:0]     cmp_a, cmp_b;
    logic                  cmp_gt;

    logic                  best_we, best_re;
    logic [NODE_IDX_W-1:0] best_waddr, best_raddr;
    logic [BOTT_W-1:0]     best_wdata, best_rdata;
    logic [FILL_W-1:0]     k_inc;
    logic                  edge_match;

    wpc_ram #(
        .WIDTH(BOTT_W),
        .DEPTH(MAX_NODES)
    ) u_best_ram (
        .clk  (clk),
        .we   (best_we),
        .waddr(best_waddr),
        .wdata(best_wdata),
        .re   (best_re),
        .raddr(best_raddr),
        .rdata(best_rdata)
    );

    assign cmp_gt     = cmp_a > cmp_b;
    assign k_inc      = k_reg + FILL_W'(1);
    assign edge_match = (edge_rdata.tail == pick_reg)
                        && ({1'b0, edge_rdata.head} < nodes_reg);
    assign edge_raddr = k_reg[EDGE_ADDR_W-1:0];
    assign edge_re    = (state_reg == S_RADDR);

    assign fin = (state_reg == S_FIN);
    assign res.bottleneck = best_vld_reg[dst_reg] ? best_rdata : '0;
    assign res.status     = best_vld_reg[dst_reg] ? ST_OK : ST_UNREACH;

    always_comb
    begin
        state_next      = state_reg;
        node_done_next  = node_done_reg;
        best_vld_next   = best_vld_reg;
        nodes_next      = nodes_reg;
        dst_next        = dst_reg;
        scan_cnt_next   = scan_cnt_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        pick_found_next = pick_found_reg;
        pick_next       = pick_reg;
        pick_val_next   = pick_val_reg;
        k_next          = k_reg;
        cand_next       = cand_reg;
        cmp_a           = '0;
        cmp_b           = '0;
        best_we         = 1'b0;
        best_waddr      = '0;
        best_wdata      = '0;
        best_re         = 1'b0;
        best_raddr      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    node_done_next          = '0;
                    best_vld_next           = '0;
                    best_vld_next[req.src]  = 1'b1;
                    best_we                 = 1'b1;
                    best_waddr              = req.src;
                    best_wdata              = CAP_UNBOUNDED;
                    nodes_next              = req.nodes;
                    dst_next                = req.dst;
                    scan_cnt_next           = '0;
                    pick_found_next         = 1'b0;
                    state_next              = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // issue the next read while comparing the previous one
                if (scan_cnt_reg < nodes_reg)
                begin
                    best_re       = 1'b1;
                    best_raddr    = scan_cnt_reg[NODE_IDX_W-1:0];
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = scan_cnt_reg[NODE_IDX_W-1:0];
                    scan_cnt_next = scan_cnt_reg + NODE_W'(1);
                end
                cmp_a = best_rdata;
                cmp_b = pick_val_reg;
                if (cmp_vld_reg)
                begin
                    if (!node_done_reg[cmp_idx_reg] && best_vld_reg[cmp_idx_reg]
                        && (!pick_found_reg || cmp_gt))
                    begin
                        pick_found_next = 1'b1;
                        pick_next       = cmp_idx_reg;
                        pick_val_next   = best_rdata;
                    end
                end
                else if (scan_cnt_reg == nodes_reg)
                begin
                    if (pick_found_reg)
                    begin
                        node_done_next[pick_reg] = 1'b1;
                        k_next = '0;
                        if (fill == '0)
                        begin
                            scan_cnt_next   = '0;
                            pick_found_next = 1'b0;
                        end
                        else
                        begin
                            state_next = S_RADDR;
                        end
                    end
                    else
                    begin
                        state_next = S_FRD;
                    end
                end
            end
            S_RADDR:
            begin
                state_next = S_REDGE;
            end
            S_REDGE:
            begin
                cmp_a = pick_val_reg;
                cmp_b = {1'b0, edge_rdata.cap};
                if (edge_match)
                begin
                    best_re    = 1'b1;
                    best_raddr = edge_rdata.head;
                    cand_next  = cmp_gt ? {1'b0, edge_rdata.cap} : pick_val_reg;
                    state_next = S_RBEST;
                end
                else
                begin
                    k_next = k_inc;
                    if (k_inc == fill)
                    begin
                        scan_cnt_next   = '0;
                        pick_found_next = 1'b0;
                        state_next      = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_RADDR;
                    end
                end
            end
            S_RBEST:
            begin
                cmp_a = cand_reg;
                cmp_b = best_rdata;
                if (!best_vld_reg[edge_rdata.head] || cmp_gt)
                begin
                    best_we                          = 1'b1;
                    best_waddr                       = edge_rdata.head;
                    best_wdata                       = cand_reg;
                    best_vld_next[edge_rdata.head]   = 1'b1;
                end
                k_next = k_inc;
                if (k_inc == fill)
                begin
                    scan_cnt_next   = '0;
                    pick_found_next = 1'b0;
                    state_next      = S_SCAN;
                end
                else
                begin
                    state_next = S_RADDR;
                end
            end
            S_FRD:
            begin
                best_re    = 1'b1;
                best_raddr = dst_reg;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_done_reg  <= '0;
            best_vld_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            pick_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_done_reg  <= node_done_next;
            best_vld_reg   <= best_vld_next;
            cmp_vld_reg    <= cmp_vld_next;
            pick_found_reg <= pick_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nodes_reg    <= nodes_next;
        dst_reg      <= dst_next;
        scan_cnt_reg <= scan_cnt_next;
        cmp_idx_reg  <= cmp_idx_next;
        pick_reg     <= pick_next;
        pick_val_reg <= pick_val_next;
        k_reg        <= k_next;
        cand_reg     <= cand_next;
    end

endmodule

[rtl/core/wpc_chk.sv]
// Port-level checker for the widest path capacity block, with its bind.
`timescale 1ns / 1ps

module wpc_chk
    import wpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [OP_W-1:0]   operation,
    input  logic              done,
    input  logic [BOTT_W-1:0] bottleneck,
    input  logic [STAT_W-1:0] status,
    input  logic              cfg_ready
);

    // Non-query requests answer on the very next cycle.
    a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (operation != OP_QUERY) |=> done && !busy)
        else $error("non-query request not answered on the next cycle");

    // A search ends with its result strobe.
    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // Failed requests carry no capacity.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != ST_OK) |-> (bottleneck == '0))
        else $error("non-zero bottleneck on a failed request");

    // Configuration stays closed while a search runs.
    a_cfg_closed: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cfg_ready)
        else $error("configuration open during a search");

endmodule

bind widest_path_capacity wpc_chk u_wpc_chk (.*);

[tb/wpc_answer_check.sv]
// Checker that predicts each widest path answer and compares it with the strobed result.
`timescale 1ns / 1ps

module wpc_answer_check
    import wpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [OP_W-1:0]   operation,
    input  logic [NODE_W-1:0] from_node,
    input  logic [NODE_W-1:0] to_node,
    input  logic [CAP_W-1:0]  edge_capacity,
    input  logic              done,
    input  logic [BOTT_W-1:0] bottleneck,
    input  logic [STAT_W-1:0] status,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [NODE_W-1:0] cfg_data,
    output int                mismatches,
    output int                pending
);

    localparam int NO_PATH      = -1;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        wpc_res_t          res;
        logic [OP_W-1:0]   op;
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
    } answer_t;

    logic [NODE_W-1:0] link_tail [MAX_EDGES];
    logic [NODE_W-1:0] link_head [MAX_EDGES];
    logic [CAP_W-1:0]  link_cap  [MAX_EDGES];
    int                link_count;
    logic [NODE_W-1:0] node_limit;
    answer_t           answers_due [$];
    int                error_count;

    // Largest bottleneck from src to dst over nodes 1..n, or NO_PATH.
    function automatic int widest_capacity(int n, int src, int dst);
        int best    [MAX_NODES+1];
        bit settled [MAX_NODES+1];
        int pick;
        int pick_val;
        int cand;
        for (int i = 0; i <= MAX_NODES; i++)
        begin
            best[i]    = NO_PATH;
            settled[i] = 1'b0;
        end
        best[src] = int'(CAP_UNBOUNDED);
        do
        begin
            pick     = 0;
            pick_val = NO_PATH;
            // strict compare keeps the lowest node on a tie
            for (int i = 1; i <= n; i++)
            begin
                if (!settled[i] && best[i] > pick_val)
                begin
                    pick     = i;
                    pick_val = best[i];
                end
            end
            if (pick != 0)
            begin
                settled[pick] = 1'b1;
                for (int k = 0; k < link_count; k++)
                begin
                    if (int'(link_tail[k]) == pick && link_head[k] >= 1 &&
                        int'(link_head[k]) <= n)
                    begin
                        cand = (int'(link_cap[k]) < pick_val) ? int'(link_cap[k]) : pick_val;
                        if (cand > best[link_head[k]])
                            best[link_head[k]] = cand;
                    end
                end
            end
        end
        while (pick != 0);
        return best[dst];
    endfunction

    // Apply one request to the edge store and return its answer.
    function automatic wpc_res_t predict_answer(logic [OP_W-1:0] op, logic [NODE_W-1:0] a,
                                                logic [NODE_W-1:0] b, logic [CAP_W-1:0] cap);
        wpc_res_t ans;
        int       n;
        int       reach;
        ans.bottleneck = '0;
        ans.status     = ST_OK;
        n = (node_limit > MAX_NODES) ? MAX_NODES : int'(node_limit);
        case (op)
            OP_ADD:
            begin
                if (a < 1 || a > MAX_NODES || b < 1 || b > MAX_NODES)
                    ans.status = ST_RANGE;
                else if (link_count >= MAX_EDGES)
                    ans.status = ST_FULL;
                else
                begin
                    link_tail[link_count] = a;
                    link_head[link_count] = b;
                    link_cap[link_count]  = cap;
                    link_count++;
                end
            end
            OP_QUERY:
            begin
                if (a < 1 || a > n || b < 1 || b > n)
                    ans.status = ST_RANGE;
                else
                begin
                    reach = widest_capacity(n, int'(a), int'(b));
                    if (reach < 0)
                        ans.status = ST_UNREACH;
                    else
                        ans.bottleneck = BOTT_W'(reach);
                end
            end
            OP_CLEAR:
                link_count = 0;
            default:
                ;
        endcase
        return ans;
    endfunction

    task automatic note_failure(input string what);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%0t: %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        answer_t due;
        answer_t fresh;
        if (!rst_n)
        begin
            link_count  = 0;
            node_limit  = '0;
            error_count = 0;
            answers_due.delete();
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            // compare first: a strobed result always belongs to an earlier request
            if (done)
            begin
                if (answers_due.size() == 0)
                    note_failure($sformatf("result with no request waiting: bottleneck %0d status %0d",
                                           bottleneck, status));
                else
                begin
                    due = answers_due.pop_front();
                    if (bottleneck !== due.res.bottleneck || status !== due.res.status)
                        note_failure($sformatf({"op %0d from %0d to %0d: bottleneck expected %0d got %0d,",
                                                " status expected %0d got %0d"},
                                               due.op, due.src, due.dst, due.res.bottleneck,
                                               bottleneck, due.res.status, status));
                end
            end
            if (start && !busy)
            begin
                fresh.op  = operation;
                fresh.src = from_node;
                fresh.dst = to_node;
                fresh.res = predict_answer(operation, from_node, to_node, edge_capacity);
                answers_due = {answers_due, fresh};
            end
            if (cfg_valid && cfg_ready)
                node_limit = cfg_data;
            mismatches <= error_count;
            pending    <= answers_due.size();
        end
    end

endmodule

[tb/testbench.sv]
// Top of the widest path capacity testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module testbench
    import wpc_pkg::*;
();

    // Operation code 3 does nothing; the package leaves it unnamed.
    localparam logic [OP_W-1:0] OP_IDLE = 2'd3;

    localparam int RANDOM_ITEMS = 1850;
    // The limit must outlast the longest legal silence, which is one query over a full store
    // or a 64 node graph.
    localparam int QUIET_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start = 1'b0;
    logic              busy;
    logic [OP_W-1:0]   operation = '0;
    logic [NODE_W-1:0] from_node = '0;
    logic [NODE_W-1:0] to_node = '0;
    logic [CAP_W-1:0]  edge_capacity = '0;
    logic              done;
    logic [BOTT_W-1:0] bottleneck;
    logic [STAT_W-1:0] status;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [NODE_W-1:0] cfg_data = '0;

    int mismatches;
    int pending;

    // Sender pacing and a rough count of stored edges, used to keep queries cheap and to fill the store.
    int burst_left = 0;
    bit steady     = 1'b0;
    int stored     = 0;
    int items_sent = 0;
    int quiet      = 0;

    widest_path_capacity dut (.*);

    wpc_answer_check answer_check (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Count cycles in which no request, result or register write moves; give up at the limit.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Present one request and hold it until the block takes it. Burst bookkeeping happens
    // here: at the end of a burst, drop start for a random gap, unless the phase runs steady.
    task automatic send(input logic [OP_W-1:0] op, input int a, input int b, input int cap);
        int gap;
        start         <= 1'b1;
        operation     <= op;
        from_node     <= NODE_W'(a);
        to_node       <= NODE_W'(b);
        edge_capacity <= CAP_W'(cap);
        do @(posedge clk); while (busy);
        if (op == OP_CLEAR)
            stored = 0;
        else if (op == OP_ADD && a >= 1 && a <= MAX_NODES && b >= 1 && b <= MAX_NODES &&
                 stored < MAX_EDGES)
            stored++;
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = steady ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
            if (!steady && $urandom_range(0, 19) == 0)
                gap = $urandom_range(15, 40);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Drop start and wait until every request has produced its result.
    task automatic settle();
        if (start)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        while (pending != 0)
            @(posedge clk);
    endtask

    // Write node_count while the block is idle.
    task automatic set_node_count(input int value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= NODE_W'(value);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly a node inside 1..n; otherwise zero or something beyond n or the node limit.
    function automatic int pick_node(int n);
        if (n >= 1 && $urandom_range(0, 9) != 0)
            return $urandom_range(1, n);
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return (n < 127) ? $urandom_range(n + 1, 127) : 0;
            default: return $urandom_range(MAX_NODES + 1, 127);
        endcase
    endfunction

    // Favour the extremes and small values so that ties and zero-capacity links turn up.
    function automatic int pick_cap();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 65535;
            2, 3:    return $urandom_range(0, 15);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    initial
    begin
        int  r;
        int  nc;
        int  n_eff;
        int  budget;
        int  query_cap;
        int  queries;
        int  len;
        int  src;
        bit  wide_graph;
        bit  store_filled;

        store_filled = 1'b0;
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. node_count is zero after reset, so any query is out of range.
        send(OP_QUERY, 1, 1, 0);
        set_node_count(5);
        send(OP_ADD, 1, 2, 100);
        send(OP_ADD, 2, 3, 50);
        send(OP_ADD, 1, 3, 30);
        send(OP_ADD, 3, 4, 0);              // zero capacity still connects
        send(OP_ADD, 0, 1, 9);              // tail zero: refused
        send(OP_ADD, 1, 65, 9);             // head above the node limit: refused
        send(OP_ADD, 127, 127, 65535);      // all ones everywhere: refused
        send(OP_ADD, 2, 3, 80);             // repeated link, wider this time
        send(OP_ADD, 5, 6, 7);              // head beyond node_count: stored, never used
        send(OP_ADD, 64, 64, 65535);
        send(OP_QUERY, 1, 3, 0);
        send(OP_QUERY, 1, 4, 0);
        send(OP_QUERY, 1, 1, 0);            // source meets itself: unbounded
        send(OP_QUERY, 4, 1, 0);            // no way back: unreachable
        send(OP_QUERY, 0, 3, 65535);
        send(OP_QUERY, 1, 6, 0);
        send(OP_IDLE, 127, 127, 65535);
        send(OP_CLEAR, 127, 127, 65535);
        send(OP_QUERY, 1, 3, 0);
        send(OP_ADD, 1, 2, 65535);
        set_node_count(127);                // saturates to the node limit
        send(OP_QUERY, 1, 2, 0);
        send(OP_QUERY, 64, 1, 0);
        send(OP_QUERY, 64, 64, 0);
        set_node_count(0);
        send(OP_QUERY, 1, 1, 0);
        set_node_count(1);
        send(OP_QUERY, 1, 1, 0);
        send(OP_QUERY, 1, 2, 0);

        // Random phases: each picks a node_count, usually clears, then mixes legal links and
        // queries with a share of broken requests. Keep the store small so searches stay short.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (!store_filled && items_sent >= 500)
            begin
                // Fill every slot with legal links, then knock on the full store.
                store_filled = 1'b1;
                nc = $urandom_range(3, 5);
                set_node_count(nc);
                send(OP_CLEAR, 0, 0, 0);
                while (stored < MAX_EDGES)
                begin
                    src = $urandom_range(1, 5);
                    send(OP_ADD, src, ($urandom_range(0, 3) == 0) ?
                         $urandom_range(1, MAX_NODES) : $urandom_range(1, 5), pick_cap());
                end
                send(OP_ADD, 1, 2, 65535);
                send(OP_ADD, 64, 64, 7);
                send(OP_ADD, 0, 2, 1);      // range is checked ahead of fullness
                repeat (3)
                    send(OP_QUERY, $urandom_range(1, nc), $urandom_range(1, nc), pick_cap());
                send(OP_QUERY, nc + 1, 1, 0);
                send(OP_CLEAR, $urandom_range(0, 127), $urandom_range(0, 127), pick_cap());
            end

            r = $urandom_range(0, 99);
            if (r < 4)
                nc = $urandom_range(0, 1);
            else if (r < 8)
                nc = $urandom_range(MAX_NODES, 127);
            else if (r < 18)
                nc = $urandom_range(11, 24);
            else
                nc = $urandom_range(2, 9);
            n_eff      = (nc > MAX_NODES) ? MAX_NODES : nc;
            wide_graph = (n_eff > 24);
            budget     = wide_graph ? 48 : 40;
            query_cap  = wide_graph ? 3 : 1000;
            set_node_count(nc);
            steady = ($urandom_range(0, 3) == 0);
            if (stored > budget || $urandom_range(0, 9) < 7)
                send(OP_CLEAR, $urandom_range(0, 127), $urandom_range(0, 127), pick_cap());

            len     = $urandom_range(20, 60);
            queries = 0;
            repeat (len)
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                begin
                    if (stored >= budget)
                        send(OP_CLEAR, $urandom_range(0, 127), $urandom_range(0, 127), pick_cap());
                    else
                        send(OP_ADD, pick_node(n_eff), pick_node(n_eff), pick_cap());
                end
                else if (r < 80)
                begin
                    if (queries < query_cap)
                    begin
                        queries++;
                        src = pick_node(n_eff);
                        send(OP_QUERY, src, ($urandom_range(0, 11) == 0) ? src : pick_node(n_eff),
                             pick_cap());
                    end
                    else
                        send(OP_IDLE, $urandom_range(0, 127), $urandom_range(0, 127), pick_cap());
                end
                else if (r < 88)
                    send(OP_ADD, ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(65, 127),
                         pick_node(n_eff), pick_cap());
                else if (r < 93)
                    send(OP_CLEAR, $urandom_range(0, 127), $urandom_range(0, 127), pick_cap());
                else
                    send(OP_IDLE, $urandom_range(0, 127), $urandom_range(0, 127), pick_cap());
            end
        end

        // Drain: wait for the last result, then a little longer for any stray strobe.
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
rtl/core/wpc_pkg.sv
rtl/core/wpc_ram.sv
rtl/core/wpc_search.sv
rtl/core/widest_path_capacity.sv
rtl/core/wpc_chk.sv
tb/wpc_answer_check.sv
tb/testbench.sv
